// ----- hdl/canf_pkg.sv -----
// shared types and constants of the can receive identifier mask filter
package canf_pkg;

  // filter table size and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ID_W    = 11;
  localparam int EIDX_W  = 4;

  // opcode field values
  localparam logic OP_PROG = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // reset value of a filter mask
  localparam logic [ID_W-1:0] MASK_ALL = {ID_W{1'b1}};

  // queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // command class given to each item by the front
  typedef enum logic [1:0] {
    CMD_PROG  = 2'd0,
    CMD_MATCH = 2'd1,
    CMD_DROP  = 2'd2
  } cmd_e;

  // input item
  typedef struct packed {
    logic              op;
    logic [EIDX_W-1:0] entry_index;
    logic [ID_W-1:0]   can_id;
    logic [ID_W-1:0]   id_mask;
    logic              remote;
  } in_t;

  // result item
  typedef struct packed {
    logic              hit;
    logic [EIDX_W-1:0] hit_index;
  } out_t;

  // classified item held in the queue
  typedef struct packed {
    cmd_e              cmd;
    logic [EIDX_W-1:0] entry_index;
    logic [ID_W-1:0]   can_id;
    logic [ID_W-1:0]   id_mask;
    logic              remote;
  } qitem_t;

  // queue head handed to the back
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

endpackage

// ----- hdl/canf_front.sv -----
// front end: accepts items, classifies them and queues them for the back end
module canf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  canf_pkg::in_t item_i,
  input  logic          pop_i,
  output canf_pkg::qhead_t head_o
);

  canf_pkg::qitem_t            q_mem [canf_pkg::QDEPTH];
  logic [canf_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [canf_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [canf_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  canf_pkg::qitem_t            cls;
  logic                        push;
  logic                        pop;

  // classify the incoming item
  always_comb begin
    cls.entry_index = item_i.entry_index;
    cls.can_id      = item_i.can_id;
    cls.id_mask     = item_i.id_mask;
    cls.remote      = item_i.remote;
    unique case (item_i.op)
      canf_pkg::OP_RECV: cls.cmd = canf_pkg::CMD_MATCH;
      default: begin
        if (32'(item_i.entry_index) < canf_pkg::ENTRIES) begin
          cls.cmd = canf_pkg::CMD_PROG;
        end else begin
          cls.cmd = canf_pkg::CMD_DROP;
        end
      end
    endcase
  end

  // queue control
  assign busy = (cnt_q == canf_pkg::QCNT_W'(canf_pkg::QDEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  // head of queue
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

endmodule

// ----- hdl/canf_back.sv -----
// back end: filter table, first-match search and result register
module canf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  canf_pkg::qhead_t head_i,
  output logic             pop_o,
  output logic             res_strobe_o,
  output canf_pkg::out_t   res_o
);

  logic [canf_pkg::ID_W-1:0]  tab_id_q   [canf_pkg::ENTRIES];
  logic                       tab_rem_q  [canf_pkg::ENTRIES];
  logic [canf_pkg::ID_W-1:0]  tab_mask_q [canf_pkg::ENTRIES];
  logic [canf_pkg::ENTRIES-1:0] valid_q;
  logic [canf_pkg::ENTRIES-1:0] match;
  logic                       found;
  logic                       sel_valid;
  logic [canf_pkg::IDX_W-1:0] sel;
  logic                       do_prog;
  logic                       do_match;
  logic                       res_strobe_q, res_strobe_d;
  canf_pkg::out_t             res_q, res_d;

  // the back end takes one item every cycle
  assign pop_o    = head_i.valid;
  assign do_prog  = head_i.valid && (head_i.item.cmd == canf_pkg::CMD_PROG);
  assign do_match = head_i.valid && (head_i.item.cmd == canf_pkg::CMD_MATCH);

  // per entry compare, remote bit always compared
  always_comb begin
    for (int e = 0; e < canf_pkg::ENTRIES; e++) begin
      match[e] = (((tab_id_q[e] ^ head_i.item.can_id) & tab_mask_q[e]) == '0) &&
                 (tab_rem_q[e] == head_i.item.remote);
    end
  end

  // priority select of the lowest matching entry
  always_comb begin
    found     = 1'b0;
    sel_valid = 1'b0;
    sel       = '0;
    for (int e = canf_pkg::ENTRIES - 1; e >= 0; e--) begin
      if (match[e]) begin
        found     = 1'b1;
        sel_valid = valid_q[e];
        sel       = canf_pkg::IDX_W'(e);
      end
    end
  end

  // result of a receive item
  always_comb begin
    res_strobe_d = do_match;
    res_d.hit       = found && sel_valid;
    res_d.hit_index = (found && sel_valid) ? canf_pkg::EIDX_W'(sel) : '0;
  end

  // filter table write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int e = 0; e < canf_pkg::ENTRIES; e++) begin
        tab_id_q[e]   <= '0;
        tab_rem_q[e]  <= 1'b0;
        tab_mask_q[e] <= canf_pkg::MASK_ALL;
      end
    end else if (do_prog) begin
      for (int e = 0; e < canf_pkg::ENTRIES; e++) begin
        if (32'(head_i.item.entry_index) == e) begin
          tab_id_q[e]   <= head_i.item.can_id;
          tab_rem_q[e]  <= head_i.item.remote;
          tab_mask_q[e] <= head_i.item.id_mask;
          valid_q[e]    <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_strobe_d) begin
      res_q <= res_d;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ----- hdl/can_rx_id_mask_filter.sv -----
// top level of the can receive identifier mask filter
//
// Usage:
//   Input channel: drive item_i and raise start; the item is taken at a rising
//   edge where start is high and busy is low. op selects program (write one
//   filter entry) or receive (search the table for a frame identifier).
//   Result channel: each receive item gives one result on res_o, marked by
//   res_strobe_o for exactly one cycle; program items give no result.
//   Order: a taken receive item is first registered in the queue; the table
//   is searched while it is at the queue head, and the result and strobe are
//   then registered in the result register that drives res_o and res_strobe_o.
//   Throughput: one item per cycle; the two-entry queue between front and
//   back drains one item each cycle, so busy stays low in normal use.
//   The search compares all entries at once and picks the lowest match (hit if valid).
//   Reset: the queue empties, entries return to identifier 0, remote 0,
//   all-ones mask, not valid; no strobe is issued.
//   The receiver cannot stall; a result is marked only in its strobe cycle.
module can_rx_id_mask_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  canf_pkg::in_t  item_i,
  output logic           res_strobe_o,
  output canf_pkg::out_t res_o
);

  canf_pkg::qhead_t head;
  logic             pop;

  // front end with queue
  canf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  // back end with table and search
  canf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // a taken receive item gives a strobe after the queue and the result register
  a_recv_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.op == canf_pkg::OP_RECV)) |-> ##2 res_strobe_o)
    else $error("receive item without result");

  // a strobe only follows a receive search
  a_strobe_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(head.valid && (head.item.cmd == canf_pkg::CMD_MATCH)))
    else $error("result strobe without receive item");

  // a miss reports index zero
  a_miss_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.hit) |-> (res_o.hit_index == '0))
    else $error("miss with nonzero index");

  // the back end keeps up, so the queue never fills
  a_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("queue full");

endmodule
